FILE: rtl/ssmd_pkg.sv
// Package for the multiplexed seven segment display driver.
// Holds request and register codes, shared types, the digit table and the pin encoder.
// No dependencies.
package ssmd_pkg;

	localparam int MAX_DIGITS_DEF        = 8;
	localparam int MIN_BRIGHTNESS_US_DEF = 2560;

	// Result fields are three bits wide, so at most eight positions ever scan.
	localparam int DIGIT_LIMIT = 8;
	localparam int CNT_W       = 4;
	localparam int OFF_W       = 16;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_CHAR   = 2'd1;
	localparam logic [1:0] REQ_UPDATE = 2'd2;

	localparam logic [1:0] CFG_BRIGHTNESS  = 2'd0;
	localparam logic [1:0] CFG_DIGIT_COUNT = 2'd1;
	localparam logic [1:0] CFG_SEG_POL     = 2'd2;
	localparam logic [1:0] CFG_DIG_POL     = 2'd3;

	localparam logic [7:0] BRIGHT_FULL = 8'hFF;
	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN
	} scan_state_t;

	// Command from the request decoder to the digit store.
	typedef struct packed {
		logic       clear;
		logic       put;
		logic       dot;
		logic       is_digit;
		logic [7:0] code;
	} store_cmd_t;

	// Segment code of a decimal digit, bit 7 is segment a, bit 0 the point.
	function automatic logic [7:0] digit_code(input logic [3:0] d);
		logic [7:0] c;
		begin
			unique case (d)
				4'd0: c = 8'hFC;
				4'd1: c = 8'h60;
				4'd2: c = 8'hDA;
				4'd3: c = 8'hF2;
				4'd4: c = 8'h66;
				4'd5: c = 8'hB6;
				4'd6: c = 8'hBE;
				4'd7: c = 8'hE0;
				4'd8: c = 8'hFE;
				4'd9: c = 8'hF6;
				default: c = 8'h00;
			endcase
			return c;
		end
	endfunction

	// Pin i is driven active when code bit 7-i is set, with per-pin polarity.
	function automatic logic [7:0] pin_levels(input logic [7:0] code, input logic [7:0] pol);
		logic [7:0] lv;
		begin
			for (int i = 0; i < 8; i++) begin
				lv[i] = ~(code[7-i] ^ pol[i]);
			end
			return lv;
		end
	endfunction

endpackage

FILE: rtl/ssmd_ifs.sv
// Channel interfaces of the display driver: request, result and register write.
// Depends on nothing; widths are those of the item fields.
interface ssmd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  char_code;
	logic [31:0] now_us;

	modport source (output valid, req_type, char_code, now_us, input ready);
	modport sink (input valid, req_type, char_code, now_us, output ready);
endinterface

interface ssmd_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] digit_index;
	logic       digit_level;
	logic [7:0] segment_levels;
	logic       last;

	modport source (output valid, digit_index, digit_level, segment_levels, last, input ready);
	modport sink (input valid, digit_index, digit_level, segment_levels, last, output ready);
endinterface

interface ssmd_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/ssmd_store.sv
// Digit code store: a shift line of segment codes plus the point-allowed flag.
// Depends on ssmd_pkg for the command struct.
module ssmd_store #(
	parameter int DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssmd_pkg::store_cmd_t          cmd,
	input  logic [ssmd_pkg::CNT_W-1:0]    n_used,
	output logic [DEPTH-1:0][7:0]         codes
);

	logic [DEPTH-1:0][7:0] codes_q;
	logic                  can_dot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q   <= '0;
			can_dot_q <= 1'b0;
		end else if (cmd.clear) begin
			codes_q   <= '0;
			can_dot_q <= 1'b0;
		end else if (cmd.dot) begin
			if (can_dot_q && n_used != '0) begin
				codes_q[0][0] <= 1'b1;
			end
		end else if (cmd.put) begin
			if (n_used == '0) begin
				can_dot_q <= 1'b0;
			end else begin
				// Only the positions in use move; the rest keep their codes.
				for (int k = 1; k < DEPTH; k++) begin
					if (ssmd_pkg::CNT_W'(k) < n_used) begin
						codes_q[k] <= codes_q[k-1];
					end
				end
				codes_q[0] <= cmd.code;
				can_dot_q  <= cmd.is_digit;
			end
		end
	end

	assign codes = codes_q;

endmodule

FILE: rtl/ssmd_scan.sv
// Scan sequencer: time check, then one stored position per unstalled cycle via
// the shared pin encoder to the result register. Depends on ssmd_pkg, ssmd_ifs.
module ssmd_scan #(
	parameter int DEPTH             = 8,
	parameter int MIN_BRIGHTNESS_US = ssmd_pkg::MIN_BRIGHTNESS_US_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [31:0]                now_us,
	input  logic [7:0]                 brightness,
	input  logic [7:0]                 seg_pol,
	input  logic [7:0]                 dig_pol,
	input  logic [ssmd_pkg::CNT_W-1:0] n_used,
	input  logic [DEPTH-1:0][7:0]      codes,
	output logic                       busy,
	ssmd_res_if.source                 res
);

	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int STEP_US    = MIN_BRIGHTNESS_US / 256;
	localparam logic [ssmd_pkg::OFF_W-1:0] MIN_US = ssmd_pkg::OFF_W'(MIN_BRIGHTNESS_US);
	localparam logic [ssmd_pkg::OFF_W-1:0] STEP   = ssmd_pkg::OFF_W'(STEP_US);

	ssmd_pkg::scan_state_t state_q, state_d;

	logic [31:0]                 now_q;
	logic [31:0]                 last_time_q;
	logic [ssmd_pkg::OFF_W-1:0]  off_q;
	logic [DEPTH-1:0]            rem_q;
	logic [IDX_W-1:0]            idx_q;
	logic                        res_valid_q;
	logic [2:0]                  res_index_q;
	logic                        res_level_q;
	logic [7:0]                  res_seg_q;
	logic                        res_last_q;

	logic [31:0]      elapsed;
	logic             full_bright;
	logic             time_due;
	logic [DEPTH-1:0] nz_mask;
	logic [DEPTH-1:0] rem_next;
	logic             step;
	logic             emit;
	logic             store_time;

	assign elapsed     = now_q - last_time_q;
	assign full_bright = (brightness == ssmd_pkg::BRIGHT_FULL);
	assign time_due    = (elapsed > {{(32-ssmd_pkg::OFF_W){1'b0}}, off_q});

	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			nz_mask[k] = (codes[k] != 8'h00) && (ssmd_pkg::CNT_W'(k) < n_used);
		end
	end

	assign rem_next = rem_q & ~(DEPTH'(1) << idx_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssmd_pkg::ST_IDLE: begin
				if (start) begin
					state_d = ssmd_pkg::ST_CHECK;
				end
			end
			ssmd_pkg::ST_CHECK: begin
				if ((full_bright || time_due) && nz_mask != '0) begin
					state_d = ssmd_pkg::ST_SCAN;
				end else begin
					state_d = ssmd_pkg::ST_IDLE;
				end
			end
			ssmd_pkg::ST_SCAN: begin
				if (step && rem_next == '0) begin
					state_d = ssmd_pkg::ST_IDLE;
				end
			end
			default: state_d = ssmd_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		busy       = 1'b0;
		step       = 1'b0;
		emit       = 1'b0;
		store_time = 1'b0;
		unique case (state_q)
			ssmd_pkg::ST_IDLE: begin
			end
			ssmd_pkg::ST_CHECK: begin
				busy       = 1'b1;
				store_time = !full_bright && time_due;
			end
			ssmd_pkg::ST_SCAN: begin
				busy = 1'b1;
				step = !res_valid_q || res.ready;
				emit = step && rem_q[idx_q];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssmd_pkg::ST_IDLE;
			last_time_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (store_time) begin
				last_time_q <= now_q;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			now_q <= now_us;
			off_q <= MIN_US - STEP * {{(ssmd_pkg::OFF_W-8){1'b0}}, brightness};
		end
		if (state_q == ssmd_pkg::ST_CHECK) begin
			rem_q <= nz_mask;
			idx_q <= '0;
		end else if (step) begin
			rem_q <= rem_next;
			idx_q <= idx_q + 1'b1;
		end
		if (emit) begin
			res_index_q <= 3'(idx_q);
			res_level_q <= dig_pol[3'(idx_q)];
			res_seg_q   <= ssmd_pkg::pin_levels(codes[idx_q], seg_pol);
			res_last_q  <= (rem_next == '0);
		end
	end

	assign res.valid          = res_valid_q;
	assign res.digit_index    = res_index_q;
	assign res.digit_level    = res_level_q;
	assign res.segment_levels = res_seg_q;
	assign res.last           = res_last_q;

endmodule

FILE: rtl/seven_segment_mux_driver_unit.sv
// Top level of the multiplexed seven segment display driver.
// Depends on ssmd_pkg, ssmd_ifs, ssmd_store and ssmd_scan.
//
//   channel  role    words carried
//   req      sink    req_type, char_code, now_us
//   res      source  digit_index, digit_level, segment_levels, last
//   cfg      sink    index, data (brightness, digit_count, polarities)
//
// Clear and character words go straight to the store, which changes at the accepting edge.
// An update word first runs the time check, then steps through each position from
// zero up to the highest nonblank position in use (at most eight), or none when the scan
// is not due or every position is blank; req is not ready during that time.
// Reset clears the stored codes, the scan time and the registers to their defaults.
// A stalled result holds the encoder; the last result may wait while the next word enters.
module seven_segment_mux_driver_unit #(
	parameter int MAX_DIGITS        = ssmd_pkg::MAX_DIGITS_DEF,
	parameter int MIN_BRIGHTNESS_US = ssmd_pkg::MIN_BRIGHTNESS_US_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ssmd_req_if.sink   req,
	ssmd_res_if.source res,
	ssmd_cfg_if.sink   cfg
);

	localparam int DEPTH = (MAX_DIGITS < ssmd_pkg::DIGIT_LIMIT) ? MAX_DIGITS
		: ssmd_pkg::DIGIT_LIMIT;

	logic [7:0]                 brightness_q;
	logic [ssmd_pkg::CNT_W-1:0] digit_count_q;
	logic [7:0]                 seg_pol_q;
	logic [7:0]                 dig_pol_q;

	logic [ssmd_pkg::CNT_W-1:0] n_used;
	logic                       accept;
	logic                       busy;
	logic                       is_digit;
	logic [DEPTH-1:0][7:0]      codes;
	ssmd_pkg::store_cmd_t       cmd;
	logic                       start;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q  <= ssmd_pkg::BRIGHT_FULL;
			digit_count_q <= ssmd_pkg::CNT_W'(4);
			seg_pol_q     <= '0;
			dig_pol_q     <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ssmd_pkg::CFG_BRIGHTNESS:  brightness_q  <= cfg.data;
				ssmd_pkg::CFG_DIGIT_COUNT: digit_count_q <= cfg.data[ssmd_pkg::CNT_W-1:0];
				ssmd_pkg::CFG_SEG_POL:     seg_pol_q     <= cfg.data;
				ssmd_pkg::CFG_DIG_POL:     dig_pol_q     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign n_used = (digit_count_q > ssmd_pkg::CNT_W'(DEPTH)) ? ssmd_pkg::CNT_W'(DEPTH)
		: digit_count_q;

	assign req.ready = !busy;
	assign accept    = req.valid && !busy;
	assign is_digit  = (req.char_code >= ssmd_pkg::CHAR_ZERO)
		&& (req.char_code <= ssmd_pkg::CHAR_NINE);

	always_comb begin
		cmd   = '0;
		start = 1'b0;
		if (accept) begin
			unique case (req.req_type)
				ssmd_pkg::REQ_CLEAR: cmd.clear = 1'b1;
				ssmd_pkg::REQ_CHAR: begin
					cmd.dot      = (req.char_code == ssmd_pkg::CHAR_DOT);
					cmd.put      = (req.char_code != ssmd_pkg::CHAR_DOT);
					cmd.is_digit = is_digit;
					cmd.code     = is_digit
						? ssmd_pkg::digit_code(4'(req.char_code - ssmd_pkg::CHAR_ZERO))
						: 8'h00;
				end
				ssmd_pkg::REQ_UPDATE: start = 1'b1;
				default: begin
				end
			endcase
		end
	end

	ssmd_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.n_used (n_used),
		.codes  (codes)
	);

	ssmd_scan #(
		.DEPTH             (DEPTH),
		.MIN_BRIGHTNESS_US (MIN_BRIGHTNESS_US)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.now_us     (req.now_us),
		.brightness (brightness_q),
		.seg_pol    (seg_pol_q),
		.dig_pol    (dig_pol_q),
		.n_used     (n_used),
		.codes      (codes),
		.busy       (busy),
		.res        (res)
	);

	// A result that is not the last of its scan leaves the sequencer still scanning.
	a_nonlast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.last |-> busy)
		else $error("non-final result while scan sequencer idle");

	// Results only name positions that are in use.
	a_index_used: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> ({1'b0, res.digit_index} < n_used))
		else $error("result names a position outside the digit count");

	// The sequencer only wakes up for an accepted update word.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(req.valid && req.ready && req.req_type == ssmd_pkg::REQ_UPDATE))
		else $error("scan started without an update word");

endmodule
